[hw/rtl/bmc_pkg.sv]
// shared types and constants for the 3x3 binary closing block
`timescale 1ns / 1ps
`default_nettype none

package bmc_pkg;

	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int PIXEL_BITS      = 8;
	localparam int MAX_HEIGHT      = 4096;
	localparam int MIN_SIZE        = 3;
	localparam int WIDTH_REG_BITS  = 11;
	localparam int HEIGHT_REG_BITS = 13;
	localparam int ROW_BITS        = 13;
	localparam int CFG_DATA_BITS   = 13;
	localparam int CFG_IDX_BITS    = 1;
	localparam int WIDTH_RESET     = 640;
	localparam int HEIGHT_RESET    = 480;

	localparam logic [PIXEL_BITS-1:0] PIX_MAX  = '1;
	localparam logic [PIXEL_BITS-1:0] PIX_ZERO = '0;

	// request kinds carried on tuser
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_DILATE = 1'b0,
		OP_ERODE  = 1'b1
	} op_t;

	// per-step flags handed from the position counters down the window chain
	typedef struct packed {
		logic d_border;
		logic e_border;
		logic emit;
		logic last;
	} step_info_t;

endpackage

`default_nettype wire

[hw/rtl/binary_morph_closing_3x3_unit.sv]
// 3x3 binary morphological closing (dilation then erosion) on a pixel stream
//
// Pixels enter on the s_ group in raster order, one per transfer, with
// s_tuser low; s_tuser high marks a flush tick whose data is ignored.
// Closed pixels (0 or 255) leave on the m_ group, m_tlast on the last
// pixel of the frame. Frame size comes from the cfg port: index 0 is the
// width, index 1 the height; a write restarts the frame.
// Output pixel p is due once input p+2W+2 is taken, so the last 2W+2
// pixels of a frame are pushed out by flush ticks (or extra pixels).
// Flush ticks before the frame's last pixel are taken and dropped.
// A result passes the s1, s2, s3 and output registers before it shows
// on m_tvalid. Throughput is one transfer per cycle, held by two cascaded
// window cells, each with a line buffer of MAX_WIDTH words that takes one
// write and one registered read per cycle, the read one address ahead.
// When m_tready is low with a result waiting, the whole chain holds and
// s_tready drops; s_tready is high whenever the output register is free
// or being emptied. Reset sets 640x480 and restarts the frame; the line
// buffers are not cleared, border pixels never look at stale entries.
`timescale 1ns / 1ps
`default_nettype none

module binary_morph_closing_3x3_unit #(
	parameter int MAX_WIDTH = bmc_pkg::MAX_WIDTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [bmc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire  [bmc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [bmc_pkg::PIXEL_BITS-1:0]     s_tdata,   // [7:0] pixel_in
	input  wire                                s_tuser,   // [0] req_type
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [bmc_pkg::PIXEL_BITS-1:0]     m_tdata,   // [7:0] pixel_out
	output logic                               m_tlast
);
	import bmc_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic                  en;
	logic                  restart;
	logic [AW-1:0]         w_m1;
	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	step_info_t            info_s1;
	logic                  valid_s2;
	step_info_t            info_s2;
	logic                  valid_s3;
	step_info_t            info_s3;
	logic                  dil_bit;
	logic                  ero_bit;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	bmc_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.en        (en),
		.restart   (restart),
		.w_m1      (w_m1),
		.valid_s1  (valid_s1),
		.pix_s1    (pix_s1),
		.info_s1   (info_s1)
	);

	bmc_stage #(
		.MAX_WIDTH (MAX_WIDTH),
		.DW        (PIXEL_BITS),
		.OP        (OP_DILATE)
	) u_dilate (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.adv       (en && valid_s1),
		.w_m1      (w_m1),
		.din       (pix_s1),
		.border_in (info_s1.d_border),
		.res       (dil_bit)
	);

	bmc_stage #(
		.MAX_WIDTH (MAX_WIDTH),
		.DW        (1),
		.OP        (OP_ERODE)
	) u_erode (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.adv       (en && valid_s2),
		.w_m1      (w_m1),
		.din       (dil_bit),
		.border_in (info_s2.e_border),
		.res       (ero_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			m_tvalid <= valid_s3 && info_s3.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			info_s2 <= info_s1;
			info_s3 <= info_s2;
			m_tdata <= ero_bit ? PIX_MAX : PIX_ZERO;
			m_tlast <= info_s3.last;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bmc_ctrl.sv]
// frame position counters, size registers and input stage of the closing block
`timescale 1ns / 1ps
`default_nettype none

module bmc_ctrl #(
	parameter int MAX_WIDTH = bmc_pkg::MAX_WIDTH_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire  [bmc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  wire  [bmc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  wire                                    s_tvalid,
	input  wire                                    s_tuser,
	input  wire  [bmc_pkg::PIXEL_BITS-1:0]         s_tdata,
	input  wire                                    en,
	output logic                                   restart,
	output logic [$clog2(MAX_WIDTH)-1:0]           w_m1,
	output logic                                   valid_s1,
	output logic [bmc_pkg::PIXEL_BITS-1:0]         pix_s1,
	output bmc_pkg::step_info_t                    info_s1
);
	import bmc_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int AW = $clog2(MAX_WIDTH);

	logic [WIDTH_REG_BITS-1:0]  width_q;
	logic [HEIGHT_REG_BITS-1:0] height_q;
	logic [WW-1:0]              w_eff;
	logic [WW-1:0]              w_last;
	logic [ROW_BITS-1:0]        h_eff;
	logic [ROW_BITS-1:0]        h_last;

	logic [WW-1:0]       qc_q, dc_q, ec_q;
	logic [ROW_BITS-1:0] qr_q, dr_q, er_q;

	logic       pix_phase;
	logic       is_pixel;
	logic       go;
	logic       d_on;
	logic       e_on;
	step_info_t info;

	// clamp the programmed size into the supported range
	always_comb begin
		if (width_q < WIDTH_REG_BITS'(MIN_SIZE)) begin
			w_eff = WW'(MIN_SIZE);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q < HEIGHT_REG_BITS'(MIN_SIZE)) begin
			h_eff = ROW_BITS'(MIN_SIZE);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = ROW_BITS'(MAX_HEIGHT);
		end else begin
			h_eff = ROW_BITS'(height_q);
		end
		w_last = w_eff - WW'(1);
		h_last = h_eff - ROW_BITS'(1);
	end

	assign w_m1    = AW'(w_last);
	assign restart = cfg_we;

	always_comb begin
		pix_phase = qr_q < h_eff;
		is_pixel  = s_tuser == REQ_PIXEL;
		// early flushes are taken and dropped; anything after the last pixel drains
		go        = s_tvalid && en && (is_pixel || !pix_phase);
		// step index has reached w+1 and 2w+2
		d_on      = (qr_q >= ROW_BITS'(2)) || (qr_q == ROW_BITS'(1) && qc_q != '0);
		e_on      = (qr_q >= ROW_BITS'(3)) || (qr_q == ROW_BITS'(2) && qc_q >= WW'(2));
		info.d_border = (dr_q == '0) || (dr_q >= h_last) || (dc_q == '0) || (dc_q == w_last);
		info.e_border = (er_q == '0) || (er_q >= h_last) || (ec_q == '0) || (ec_q == w_last);
		info.emit     = e_on;
		info.last     = e_on && (er_q == h_last) && (ec_q == w_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_BITS'(WIDTH_RESET);
			height_q <= HEIGHT_REG_BITS'(HEIGHT_RESET);
			qc_q     <= '0;
			qr_q     <= '0;
			dc_q     <= '0;
			dr_q     <= '0;
			ec_q     <= '0;
			er_q     <= '0;
			valid_s1 <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_REG_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_BITS-1:0];
				default:          ;
			endcase
			qc_q     <= '0;
			qr_q     <= '0;
			dc_q     <= '0;
			dr_q     <= '0;
			ec_q     <= '0;
			er_q     <= '0;
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= go;
			if (go) begin
				if (info.last) begin
					qc_q <= '0;
					qr_q <= '0;
					dc_q <= '0;
					dr_q <= '0;
					ec_q <= '0;
					er_q <= '0;
				end else begin
					if (qc_q == w_last) begin
						qc_q <= '0;
						qr_q <= qr_q + ROW_BITS'(1);
					end else begin
						qc_q <= qc_q + WW'(1);
					end
					if (d_on) begin
						if (dc_q == w_last) begin
							dc_q <= '0;
							dr_q <= dr_q + ROW_BITS'(1);
						end else begin
							dc_q <= dc_q + WW'(1);
						end
					end
					if (e_on) begin
						if (ec_q == w_last) begin
							ec_q <= '0;
							er_q <= er_q + ROW_BITS'(1);
						end else begin
							ec_q <= ec_q + WW'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && go) begin
			pix_s1  <= s_tdata;
			info_s1 <= info;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bmc_stage.sv]
// one 3x3 window cell: two-row line buffer, window registers and min/max rule
`timescale 1ns / 1ps
`default_nettype none

module bmc_stage #(
	parameter int          MAX_WIDTH = bmc_pkg::MAX_WIDTH_DEF,
	parameter int          DW        = bmc_pkg::PIXEL_BITS,
	parameter bmc_pkg::op_t OP       = bmc_pkg::OP_DILATE
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          restart,
	input  wire                          adv,
	input  wire  [$clog2(MAX_WIDTH)-1:0] w_m1,
	input  wire  [DW-1:0]                din,
	input  wire                          border_in,
	output logic                         res
);
	import bmc_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	// each word holds the pixel one row back (high) and the current one (low)
	logic [2*DW-1:0] mem [MAX_WIDTH];
	logic [2*DW-1:0] rd_q;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   ptr_nx;
	logic [DW-1:0]   win_q [3][3];
	logic            border_q;
	logic            hit;

	always_comb begin
		priority if (restart) begin
			ptr_nx = '0;
		end else if (adv) begin
			ptr_nx = (ptr_q == w_m1) ? '0 : ptr_q + AW'(1);
		end else begin
			ptr_nx = ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else begin
			ptr_q <= ptr_nx;
		end
	end

	// rd_q always shows the entry at ptr_q, written one row of transfers ago
	always_ff @(posedge clk) begin
		if (adv) begin
			mem[ptr_q] <= {rd_q[DW-1:0], din};
		end
		rd_q <= mem[ptr_nx];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			win_q[0][0] <= rd_q[2*DW-1:DW];
			win_q[1][0] <= rd_q[DW-1:0];
			win_q[2][0] <= din;
			for (int r = 0; r < 3; r++) begin
				win_q[r][1] <= win_q[r][0];
				win_q[r][2] <= win_q[r][1];
			end
			border_q <= border_in;
		end
	end

	always_comb begin
		unique case (OP)
			OP_DILATE: begin
				hit = win_q[1][1] != '0;
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						hit = hit | (win_q[r][c] == '1);
					end
				end
			end
			OP_ERODE: begin
				hit = 1'b1;
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						hit = hit & (win_q[r][c] != '0);
					end
				end
			end
			default: hit = 1'b0;
		endcase
	end

	assign res = !border_q && hit;

endmodule

`default_nettype wire

[hw/rtl/bmc_checker.sv]
// port-level checks for the closing block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bmc_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                s_tready,
	input wire                                m_tvalid,
	input wire                                m_tready,
	input wire [bmc_pkg::PIXEL_BITS-1:0]      m_tdata,
	input wire                                m_tlast
);
	import bmc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output changed");

	// closing yields a binary picture
	a_out_binary: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == PIX_MAX) || (m_tdata == PIX_ZERO))
		else $error("output pixel is neither 0 nor 255");

	// input side is open exactly when the output register can take a result
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready out of step with output register");

endmodule

bind binary_morph_closing_3x3_unit bmc_checker u_bmc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

[test/binary_morph_closing_3x3_unit_tb.sv]
// self-checking testbench for the 3x3 binary closing unit, with its own pixel-level predictor
`timescale 1ns / 1ps
`default_nettype none

module binary_morph_closing_3x3_unit_tb;
	import bmc_pkg::*;

	localparam int unsigned RING_DEPTH    = 2 * MAX_WIDTH_DEF + 4;
	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned RANDOM_ITEMS  = 950;
	localparam int unsigned CALM_START    = 600;
	localparam int unsigned CALM_END      = 1200;

	typedef struct packed {
		logic                  kind;
		logic [PIXEL_BITS-1:0] pixel;
	} pixel_item_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		logic                  last;
	} closed_pixel_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_we    = 1'b0;
	cfg_reg_t                 cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [PIXEL_BITS-1:0]    s_tdata   = '0;        // [7:0] pixel_in
	logic                     s_tuser   = REQ_PIXEL; // [0] req_type
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [PIXEL_BITS-1:0]    m_tdata;               // [7:0] pixel_out
	logic                     m_tlast;

	// predictor state
	logic [WIDTH_REG_BITS-1:0]  width_reg  = WIDTH_REG_BITS'(WIDTH_RESET);
	logic [HEIGHT_REG_BITS-1:0] height_reg = HEIGHT_REG_BITS'(HEIGHT_RESET);
	logic [PIXEL_BITS-1:0]      pixel_ring [RING_DEPTH];
	logic                       dilated_ring [RING_DEPTH];
	int unsigned                pixels_taken = 0;
	int unsigned                pixels_sent  = 0;

	pixel_item_t   pending_items [$];
	closed_pixel_t expected_pixels [$];

	int unsigned mismatches   = 0;
	int unsigned cycle_count  = 0;
	int unsigned offers       = 0;
	int unsigned transfers_in = 0;
	int unsigned workload     = 0;

	binary_morph_closing_3x3_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned frame_width();
		int unsigned w;
		w = 32'(width_reg);
		if (w < MIN_SIZE) return MIN_SIZE;
		if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return w;
	endfunction

	function automatic int unsigned frame_height();
		int unsigned h;
		h = 32'(height_reg);
		if (h < MIN_SIZE) return MIN_SIZE;
		if (h > MAX_HEIGHT) return MAX_HEIGHT;
		return h;
	endfunction

	function automatic bit on_edge(int unsigned x, int unsigned w, int unsigned h);
		int unsigned r, c;
		r = x / w;
		c = x % w;
		return r == 0 || r >= h - 1 || c == 0 || c == w - 1;
	endfunction

	function automatic logic dilate_bit(int unsigned d, int unsigned w, int unsigned h);
		int unsigned x;
		if (on_edge(d, w, h)) return 1'b0;
		if (pixel_ring[d % RING_DEPTH] != PIX_ZERO) return 1'b1;
		for (int dr = 0; dr < 3; dr++) begin
			for (int dc = 0; dc < 3; dc++) begin
				x = d + dr * w + dc - w - 1;
				if (pixel_ring[x % RING_DEPTH] == PIX_MAX) return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [PIXEL_BITS-1:0] erode_pixel(int unsigned e, int unsigned w,
			int unsigned h);
		int unsigned x;
		if (on_edge(e, w, h)) return PIX_ZERO;
		for (int dr = 0; dr < 3; dr++) begin
			for (int dc = 0; dc < 3; dc++) begin
				x = e + dr * w + dc - w - 1;
				if (dilated_ring[x % RING_DEPTH] == 1'b0) return PIX_ZERO;
			end
		end
		return PIX_MAX;
	endfunction

	// advances the predictor by one accepted item; returns 1 when a pixel is due out
	function automatic bit closing_step(input pixel_item_t item, output closed_pixel_t res);
		int unsigned w, h, n, lag, q, d;
		w = frame_width();
		h = frame_height();
		n = w * h;
		lag = 2 * w + 2;
		res = '0;
		if (pixels_taken < n) begin
			if (item.kind == REQ_FLUSH) return 1'b0;
			q = pixels_taken;
			pixel_ring[q % RING_DEPTH] = item.pixel;
			pixels_taken = q + 1;
			if (q >= w + 1) begin
				d = q - w - 1;
				dilated_ring[d % RING_DEPTH] = dilate_bit(d, w, h);
			end
			if (q < lag) return 1'b0;
		end else begin
			// draining: the pixel that would have arrived now still has to be dilated
			d = pixels_sent + lag - w - 1;
			if (d < n) dilated_ring[d % RING_DEPTH] = dilate_bit(d, w, h);
		end
		res.pixel = erode_pixel(pixels_sent, w, h);
		pixels_sent++;
		if (pixels_sent >= n) begin
			res.last = 1'b1;
			pixels_taken = 0;
			pixels_sent = 0;
		end
		return 1'b1;
	endfunction

	function automatic bit take_break();
		if (cycle_count >= CALM_START && cycle_count < CALM_END) return 1'b0;
		return $urandom_range(99) < 31;
	endfunction

	task automatic report_mismatch(input string what, input logic [PIXEL_BITS-1:0] got,
			input logic [PIXEL_BITS-1:0] want);
		mismatches++;
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic queue_item(input logic kind, input logic [PIXEL_BITS-1:0] pixel);
		pending_items.push_back('{kind: kind, pixel: pixel});
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_BITS-1:0];
		if (idx == REG_IMAGE_WIDTH) width_reg = value[WIDTH_REG_BITS-1:0];
		else height_reg = value[HEIGHT_REG_BITS-1:0];
		// any write restarts the frame
		pixels_taken = 0;
		pixels_sent = 0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_frame_size(input int unsigned wdata, input int unsigned hdata);
		wait_drained();
		write_reg(REG_IMAGE_WIDTH, wdata);
		write_reg(REG_IMAGE_HEIGHT, hdata);
	endtask

	// one frame of random content and its drain; cut stops the stream part way
	task automatic queue_frame(input bit cut);
		int unsigned w, h, n, lag, limit, density;
		logic [PIXEL_BITS-1:0] pix;
		w = frame_width();
		h = frame_height();
		n = w * h;
		lag = 2 * w + 2;
		limit = cut ? $urandom_range(n + lag - 1, 1) : n + lag;
		density = $urandom_range(90, 10);
		for (int unsigned i = 0; i < limit; i++) begin
			if (i < n) begin
				// stray flush inside the frame, dropped by the block
				if ($urandom_range(99) < 4)
					queue_item(REQ_FLUSH, PIXEL_BITS'($urandom_range(255)));
				if ($urandom_range(99) < 8) pix = PIXEL_BITS'($urandom_range(255));
				else pix = ($urandom_range(99) < density) ? PIX_MAX : PIX_ZERO;
				queue_item(REQ_PIXEL, pix);
			end else begin
				queue_item($urandom_range(99) < 80 ? REQ_FLUSH : REQ_PIXEL,
					PIXEL_BITS'($urandom_range(255)));
			end
		end
		workload += limit;
	endtask

	// slave side: hold an offered transfer until taken, else offer the next item or idle
	always @(negedge clk) begin
		if (!(s_tvalid && offers != transfers_in)) begin
			if (pending_items.size() != 0 && !take_break()) begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_items[0].pixel;
				s_tuser  <= pending_items[0].kind;
				offers   <= offers + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : input_side
		closed_pixel_t predicted;
		if (arst_n && s_tvalid && s_tready) begin
			if (closing_step('{kind: s_tuser, pixel: s_tdata}, predicted))
				expected_pixels.push_back(predicted);
			void'(pending_items.pop_front());
			transfers_in <= transfers_in + 1;
		end
	end

	always @(negedge clk) begin
		m_tready <= !take_break();
	end

	always @(posedge clk) begin : output_side
		closed_pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("result with nothing due", m_tdata, PIX_ZERO);
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata !== want.pixel) report_mismatch("pixel_out", m_tdata, want.pixel);
				if (m_tlast !== want.last)
					report_mismatch("last_of_frame", PIXEL_BITS'(m_tlast),
						PIXEL_BITS'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned wdata, hdata, frames;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// under the reset size nothing comes out; the write below restarts the frame
		queue_item(REQ_PIXEL, PIX_MAX);
		queue_item(REQ_FLUSH, PIX_ZERO);

		set_frame_size(MIN_SIZE, MIN_SIZE);
		queue_item(REQ_PIXEL, 8'h00);
		queue_item(REQ_PIXEL, 8'hFF);
		queue_item(REQ_PIXEL, 8'h01);
		queue_item(REQ_FLUSH, 8'hFF);
		queue_item(REQ_PIXEL, 8'hFE);
		queue_item(REQ_PIXEL, 8'h00);
		queue_item(REQ_PIXEL, 8'hFF);
		queue_item(REQ_PIXEL, 8'h7F);
		queue_item(REQ_PIXEL, 8'h80);
		queue_item(REQ_PIXEL, 8'hFF);
		// drain, with surplus pixels standing in for flush ticks
		queue_item(REQ_FLUSH, 8'h00);
		queue_item(REQ_PIXEL, 8'h55);
		repeat (5) queue_item(REQ_FLUSH, 8'h00);
		queue_item(REQ_PIXEL, 8'hAA);
		// frame has ended, so this one is early for the next frame
		queue_item(REQ_FLUSH, 8'hFF);

		while (workload < RANDOM_ITEMS) begin
			wdata = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(16, 3);
			hdata = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(10, 3);
			frames = $urandom_range(3, 1);
			wait_drained();
			case ($urandom_range(2))
				0: write_reg(REG_IMAGE_WIDTH, wdata);
				1: write_reg(REG_IMAGE_HEIGHT, hdata);
				default: begin
					write_reg(REG_IMAGE_WIDTH, wdata);
					write_reg(REG_IMAGE_HEIGHT, hdata);
				end
			endcase
			for (int f = 1; f <= frames; f++)
				queue_frame(f == frames && $urandom_range(99) < 15);
		end

		// size extremes, clamped ones among them
		set_frame_size(0, 0);
		queue_frame(1'b0);
		set_frame_size(2, 1);
		queue_frame(1'b0);
		// only the low bits of the write reach the width register
		set_frame_size(13'h0803, MIN_SIZE);
		queue_frame(1'b0);

		wait_drained();
		if (mismatches == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
hw/rtl/bmc_pkg.sv
hw/rtl/bmc_ctrl.sv
hw/rtl/bmc_stage.sv
hw/rtl/binary_morph_closing_3x3_unit.sv
hw/rtl/bmc_checker.sv
test/binary_morph_closing_3x3_unit_tb.sv
